// ----- design/iwd_pkg.sv -----
// Package for the input word debouncer: sizes, bit position tables,
// configuration register indexes and the result bundle type.
// No dependencies.
`default_nettype none
package iwd_pkg;

    localparam int WORD_W        = 32;
    localparam int POS_W         = 5;
    localparam int CNT_W         = 8;
    localparam int STREAK_W      = 8;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 8;

    localparam int PAD_BITS      = 9;
    localparam int SYS_BITS      = 11;
    localparam int PAD_TABLE_LEN = 9;
    localparam int SYS_TABLE_LEN = 11;
    localparam int PAD_OUT_W     = 9;
    localparam int SYS_OUT_W     = 11;

    localparam int PAD_LANES = (PAD_BITS < PAD_TABLE_LEN) ? PAD_BITS : PAD_TABLE_LEN;
    localparam int SYS_LANES = (SYS_BITS < SYS_TABLE_LEN) ? SYS_BITS : SYS_TABLE_LEN;

    localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET  = CFG_DATA_W'(2);
    localparam logic [CFG_DATA_W-1:0] FAIL_LIMIT_RESET = CFG_DATA_W'(5);

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_LIMIT         = CFG_INDEX_W'(1);

    // pads are active low, system buttons active high
    localparam logic [POS_W-1:0] PAD_POS [PAD_TABLE_LEN] = '{
        5'd0, 5'd1, 5'd8, 5'd2, 5'd3, 5'd7, 5'd4, 5'd5, 5'd6
    };
    localparam logic [POS_W-1:0] SYS_POS [SYS_TABLE_LEN] = '{
        5'd25, 5'd24, 5'd28, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23
    };

    typedef struct packed {
        logic [PAD_OUT_W-1:0] pad_stable_bits;
        logic [SYS_OUT_W-1:0] sys_stable_bits;
        logic                 link_ok;
    } iwd_result_t;

endpackage
`default_nettype wire

// ----- design/iwd_debounce.sv -----
// Debounce state: stable bits, per-bit counters and failure streak.
// Computes the next state and the result for one request. Uses iwd_pkg.
`default_nettype none
module iwd_debounce (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             update,
    input  wire logic                             read_ok,
    input  wire logic [iwd_pkg::WORD_W-1:0]       jamma_word,
    input  wire logic [iwd_pkg::CFG_DATA_W-1:0]   threshold,
    input  wire logic [iwd_pkg::CFG_DATA_W-1:0]   fail_limit,
    output iwd_pkg::iwd_result_t                  result
);
    import iwd_pkg::*;

    logic [PAD_OUT_W-1:0] pad_stable_reg, pad_stable_next;
    logic [SYS_OUT_W-1:0] sys_stable_reg, sys_stable_next;
    logic [CNT_W-1:0]     pad_cnt_reg [PAD_LANES];
    logic [CNT_W-1:0]     pad_cnt_next [PAD_LANES];
    logic [CNT_W-1:0]     sys_cnt_reg [SYS_LANES];
    logic [CNT_W-1:0]     sys_cnt_next [SYS_LANES];
    logic [STREAK_W-1:0]  streak_reg, streak_next;
    logic                 link_next;

    always_comb begin
        logic             raw;
        logic [CNT_W-1:0] inc;
        pad_stable_next = pad_stable_reg;
        pad_cnt_next    = pad_cnt_reg;
        raw = 1'b0;
        inc = '0;
        if (read_ok) begin
            for (int i = 0; i < PAD_LANES; i++) begin
                raw = ~jamma_word[PAD_POS[i]];
                inc = pad_cnt_reg[i] + CNT_W'(1);
                if (raw == pad_stable_reg[i]) begin
                    pad_cnt_next[i] = '0;
                end else if (inc < threshold) begin
                    pad_cnt_next[i] = inc;
                end else begin
                    pad_cnt_next[i]    = '0;
                    pad_stable_next[i] = raw;
                end
            end
        end
    end

    always_comb begin
        logic             raw;
        logic [CNT_W-1:0] inc;
        sys_stable_next = sys_stable_reg;
        sys_cnt_next    = sys_cnt_reg;
        raw = 1'b0;
        inc = '0;
        if (read_ok) begin
            for (int i = 0; i < SYS_LANES; i++) begin
                raw = jamma_word[SYS_POS[i]];
                inc = sys_cnt_reg[i] + CNT_W'(1);
                if (raw == sys_stable_reg[i]) begin
                    sys_cnt_next[i] = '0;
                end else if (inc < threshold) begin
                    sys_cnt_next[i] = inc;
                end else begin
                    sys_cnt_next[i]    = '0;
                    sys_stable_next[i] = raw;
                end
            end
        end
    end

    always_comb begin
        if (read_ok) begin
            streak_next = '0;
            link_next   = 1'b1;
        end else begin
            streak_next = (streak_reg == STREAK_MAX) ? streak_reg
                                                     : streak_reg + STREAK_W'(1);
            link_next   = (streak_next <= fail_limit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_stable_reg <= '0;
            sys_stable_reg <= '0;
            streak_reg     <= '0;
            for (int i = 0; i < PAD_LANES; i++) pad_cnt_reg[i] <= '0;
            for (int i = 0; i < SYS_LANES; i++) sys_cnt_reg[i] <= '0;
        end else if (update) begin
            pad_stable_reg <= pad_stable_next;
            sys_stable_reg <= sys_stable_next;
            streak_reg     <= streak_next;
            pad_cnt_reg    <= pad_cnt_next;
            sys_cnt_reg    <= sys_cnt_next;
        end
    end

    assign result.pad_stable_bits = pad_stable_next;
    assign result.sys_stable_bits = sys_stable_next;
    assign result.link_ok         = link_next;

endmodule
`default_nettype wire

// ----- design/input_word_debouncer.sv -----
// Input word debouncer top level: input register, configuration
// registers and result register around iwd_debounce. Uses iwd_pkg.
// Requests pass the input register, then the result register, to result valid.
// Throughput: one request per cycle while m_ready does not stall the result;
// the state update sits between the input register and the result register.
// Reset: synchronous active low; clears state, counters, streak, valids,
// and restores threshold 2 and fail limit 5.
`default_nettype none
module input_word_debouncer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic                             s_read_ok,
    input  wire logic [iwd_pkg::WORD_W-1:0]       s_jamma_word,
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic [iwd_pkg::PAD_OUT_W-1:0]    m_pad_stable_bits,
    output      logic [iwd_pkg::SYS_OUT_W-1:0]    m_sys_stable_bits,
    output      logic                             m_link_ok,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [iwd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [iwd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import iwd_pkg::*;

    logic                  in_valid_reg;
    logic                  read_ok_reg;
    logic [WORD_W-1:0]     word_reg;
    logic                  out_valid_reg;
    iwd_result_t           result_reg;
    iwd_result_t           result_next;
    logic [CFG_DATA_W-1:0] threshold_reg;
    logic [CFG_DATA_W-1:0] fail_limit_reg;
    logic                  advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RESET;
            fail_limit_reg <= FAIL_LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DEBOUNCE_THRESHOLD: threshold_reg  <= cfg_data;
                CFG_FAIL_LIMIT:         fail_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            read_ok_reg <= s_read_ok;
            word_reg    <= s_jamma_word;
        end
    end

    iwd_debounce u_debounce (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .read_ok    (read_ok_reg),
        .jamma_word (word_reg),
        .threshold  (threshold_reg),
        .fail_limit (fail_limit_reg),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_pad_stable_bits = result_reg.pad_stable_bits;
    assign m_sys_stable_bits = result_reg.sys_stable_bits;
    assign m_link_ok         = result_reg.link_ok;

endmodule
`default_nettype wire

// ----- test/input_word_debouncer_chk.sv -----
`timescale 1ns / 100ps
// Checker for input_word_debouncer: watches the request, result and register
// channels, predicts each result and compares it field by field.
// Depends on iwd_pkg for the result type, register indexes and reset values.
module input_word_debouncer_chk (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_read_ok,
    input  logic [iwd_pkg::WORD_W-1:0]      s_jamma_word,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [iwd_pkg::PAD_OUT_W-1:0]   m_pad_stable_bits,
    input  logic [iwd_pkg::SYS_OUT_W-1:0]   m_sys_stable_bits,
    input  logic                            m_link_ok,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [iwd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [iwd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              outstanding
);
    import iwd_pkg::*;

    localparam int PAD_N = 9;
    localparam int SYS_N = 11;

    // word bit feeding each lane; pads active low, system buttons active high
    localparam logic [4:0] PAD_WORD_BIT [PAD_N] = '{
        5'd0, 5'd1, 5'd8, 5'd2, 5'd3, 5'd7, 5'd4, 5'd5, 5'd6
    };
    localparam logic [4:0] SYS_WORD_BIT [SYS_N] = '{
        5'd25, 5'd24, 5'd28, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23
    };

    logic [7:0]           flip_count;
    logic [7:0]           link_limit;
    logic [PAD_N-1:0]     pad_level;
    logic [SYS_N-1:0]     sys_level;
    logic [7:0]           pad_run [PAD_N];
    logic [7:0]           sys_run [SYS_N];
    logic [7:0]           fail_run;
    iwd_result_t          debounced_due [$];
    iwd_result_t          want;

    initial begin
        mismatches = 0;
    end

    // returns {level, run} of one lane after one good sample
    function automatic logic [8:0] lane_step(input logic level, input logic [7:0] run,
                                             input logic raw);
        logic [7:0] bumped;
        if (raw == level) return {level, 8'd0};
        bumped = run + 8'd1;
        if (bumped < flip_count) return {level, bumped};
        return {raw, 8'd0};
    endfunction

    function automatic iwd_result_t advance_debounce(input logic ok, input logic [31:0] word);
        iwd_result_t res;
        logic        link;
        if (ok) begin
            fail_run = '0;
            for (int i = 0; i < PAD_N; i++)
                {pad_level[i], pad_run[i]} = lane_step(pad_level[i], pad_run[i],
                                                       ~word[PAD_WORD_BIT[i]]);
            for (int i = 0; i < SYS_N; i++)
                {sys_level[i], sys_run[i]} = lane_step(sys_level[i], sys_run[i],
                                                       word[SYS_WORD_BIT[i]]);
            link = 1'b1;
        end else begin
            if (fail_run != 8'hFF) fail_run = fail_run + 8'd1;
            link = (fail_run <= link_limit);
        end
        res.pad_stable_bits = pad_level;
        res.sys_stable_bits = sys_level;
        res.link_ok         = link;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            flip_count = THRESHOLD_RESET;
            link_limit = FAIL_LIMIT_RESET;
            pad_level  = '0;
            sys_level  = '0;
            fail_run   = '0;
            for (int i = 0; i < PAD_N; i++) pad_run[i] = '0;
            for (int i = 0; i < SYS_N; i++) sys_run[i] = '0;
            debounced_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE_THRESHOLD: flip_count = cfg_data;
                    CFG_FAIL_LIMIT:         link_limit = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (debounced_due.size() == 0) begin
                    $error("result with no request pending: pad %h sys %h link %b",
                           m_pad_stable_bits, m_sys_stable_bits, m_link_ok);
                    mismatches++;
                end else begin
                    want = debounced_due.pop_front();
                    if (m_pad_stable_bits !== want.pad_stable_bits) begin
                        $error("pad_stable_bits expected %h got %h",
                               want.pad_stable_bits, m_pad_stable_bits);
                        mismatches++;
                    end
                    if (m_sys_stable_bits !== want.sys_stable_bits) begin
                        $error("sys_stable_bits expected %h got %h",
                               want.sys_stable_bits, m_sys_stable_bits);
                        mismatches++;
                    end
                    if (m_link_ok !== want.link_ok) begin
                        $error("link_ok expected %b got %b", want.link_ok, m_link_ok);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready)
                debounced_due.push_back(advance_debounce(s_read_ok, s_jamma_word));
        end
        outstanding <= debounced_due.size();
    end

endmodule

// ----- test/input_word_debouncer_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for input_word_debouncer: clock, reset, request and register
// stimulus, result back-pressure and the verdict.
// Depends on iwd_pkg, input_word_debouncer and input_word_debouncer_chk.
module input_word_debouncer_tb;
    import iwd_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_read_ok    = 1'b0;
    logic [WORD_W-1:0]      s_jamma_word = '0;
    logic                   m_ready      = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    wire                    s_ready;
    wire                    m_valid;
    wire  [PAD_OUT_W-1:0]   m_pad_stable_bits;
    wire  [SYS_OUT_W-1:0]   m_sys_stable_bits;
    wire                    m_link_ok;
    wire                    cfg_ready;
    int                     mismatches;
    int                     outstanding;

    bit idle_on      = 1'b1;
    bit hold_results = 1'b0;

    always #5 aclk = ~aclk;

    input_word_debouncer u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_read_ok         (s_read_ok),
        .s_jamma_word      (s_jamma_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pad_stable_bits (m_pad_stable_bits),
        .m_sys_stable_bits (m_sys_stable_bits),
        .m_link_ok         (m_link_ok),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    input_word_debouncer_chk u_chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_read_ok         (s_read_ok),
        .s_jamma_word      (s_jamma_word),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pad_stable_bits (m_pad_stable_bits),
        .m_sys_stable_bits (m_sys_stable_bits),
        .m_link_ok         (m_link_ok),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .outstanding       (outstanding)
    );

    task automatic offer_sample(input logic ok, input logic [WORD_W-1:0] word);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_read_ok    <= ok;
        s_jamma_word <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEBOUNCE_THRESHOLD;
        cfg_data  <= thr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_FAIL_LIMIT;
        cfg_data  <= lim;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // held words with occasional single-bit bounce and bursts of failed reads
    task automatic run_phase(input int count, input int run_lo, input int run_hi,
                             input int fail_hi);
        logic [WORD_W-1:0] base;
        int                run_left;
        int                fail_left;
        base      = $urandom;
        run_left  = 0;
        fail_left = 0;
        for (int sent = 0; sent < count; sent++) begin
            if (fail_left == 0 && $urandom_range(0, 19) == 0)
                fail_left = $urandom_range(1, fail_hi);
            if (fail_left > 0) begin
                offer_sample(1'b0, $urandom);
                fail_left--;
            end else begin
                if (run_left == 0) begin
                    base     = ($urandom_range(0, 3) == 0) ? $urandom
                                                           : base ^ ($urandom & $urandom);
                    run_left = $urandom_range(run_lo, run_hi);
                end
                run_left--;
                offer_sample(1'b1, ($urandom_range(0, 7) == 0)
                                   ? base ^ (32'h1 << $urandom_range(0, 31)) : base);
            end
        end
    endtask

    // result side back-pressure
    initial begin
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: threshold 2, fail limit 5
        offer_sample(1'b1, 32'hFFFF_FFFF);
        offer_sample(1'b1, 32'hFFFF_FFFF);
        offer_sample(1'b1, 32'h0000_0000);
        offer_sample(1'b0, 32'hFFFF_FFFF);
        offer_sample(1'b1, 32'h0000_0000);
        offer_sample(1'b1, 32'h0000_0000);
        repeat (7) offer_sample(1'b0, $urandom);
        offer_sample(1'b1, 32'hA5A5_5A5A);
        offer_sample(1'b1, 32'h5A5A_A5A5);
        offer_sample(1'b1, 32'h5A5A_A5A5);
        offer_sample(1'b1, 32'hFFFF_FFFF);
        offer_sample(1'b1, 32'hFFFF_FFFF);

        // threshold lowered while lanes are mid-count
        quiesce();
        set_config(8'd10, 8'd5);
        repeat (12) offer_sample(1'b1, 32'h00FF_00FF);
        repeat (6) offer_sample(1'b1, 32'hFF00_FF00);
        quiesce();
        set_config(8'd3, 8'd5);
        repeat (2) offer_sample(1'b1, 32'hFF00_FF00);

        quiesce();
        set_config(8'd0, 8'd0);
        run_phase(220, 1, 4, 4);

        quiesce();
        set_config(8'd1, 8'd255);
        run_phase(220, 1, 5, 10);

        quiesce();
        set_config(8'd3, 8'd1);
        run_phase(250, 1, 10, 4);

        // streak runs into saturation, link must stay down
        quiesce();
        set_config(8'd255, 8'd254);
        repeat (258) offer_sample(1'b0, $urandom);
        run_phase(320, 260, 330, 3);

        quiesce();
        set_config(8'd7, 8'd3);
        run_phase(110, 1, 18, 6);
        idle_on      = 1'b0;
        hold_results = 1'b1;
        repeat (40) offer_sample(1'b1, $urandom);
        idle_on = 1'b1;
        run_phase(110, 1, 18, 6);

        quiesce();
        set_config(8'd2, 8'd5);
        idle_on = 1'b0;
        run_phase(160, 1, 6, 8);

        quiesce();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
